// ===== hdl/tga_rle_pkg.sv =====
// Shared types and constants for the Targa run-length pixel encoder.
package tga_rle_pkg;

  localparam int IDX_W             = 8;
  localparam int PIX_W             = 24;
  localparam int HDR_W             = 8;
  localparam int CNT_W             = 3;
  localparam int PIXELS_PER_RESULT = 4;
  localparam int SLOT_W            = $clog2(PIXELS_PER_RESULT);

  localparam logic [HDR_W-1:0] RUN_FLAG   = 8'h80;
  localparam logic [HDR_W-1:0] COUNT_MASK = 8'h7F;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_RUN_A = 3'd1,
    ST_LIT_A = 3'd2,
    ST_RUN_B = 3'd3,
    ST_WRITE = 3'd4,
    ST_LIT_E = 3'd5,
    ST_RUN_E = 3'd6
  } state_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             end_of_image;
  } enc_in_t;

  typedef struct packed {
    logic             has_header;
    logic [HDR_W-1:0] header_byte;
    logic [CNT_W-1:0] pixel_count;
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic [PIX_W-1:0] pixel_c;
    logic [PIX_W-1:0] pixel_d;
    logic             last_of_step;
    logic             image_done;
  } enc_out_t;

endpackage

// ===== hdl/tga_rle_pixel_encoder_core.sv =====
// Targa RLE pixel encoder: packet sequencer, literal store and palette lookup.
// A palette write (cmd 0) needs only its accept. A pixel that is stored as a
// literal passes its accept, then the literal store write; a pixel that only
// extends a run needs only its accept. Emitting issues each packet pixel: a
// repeat packet issues one, a literal flush of n pixels issues n, because the
// literal store has one read port and delivers one pixel per cycle unless the
// output stalls. Issued pixels pass a read pipeline (literal store, then
// palette) into a four-pixel assembly register and the output register; the
// next item is taken once the palette read stage is clear, and a stalled output
// holds the pipeline. Palette and literal store need no clearing pass after reset.
module tga_rle_pixel_encoder_core #(
  parameter int MAX_PACKET    = 128,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tga_rle_pkg::enc_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tga_rle_pkg::enc_out_t out_data
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int AW = $clog2(MAX_PACKET);
  localparam int PW = $clog2(PALETTE_DEPTH);

  typedef struct packed {
    logic [CW-1:0] run_a_n;
    logic [CW-1:0] lit_a_n;
    logic          run_b;
    logic          wr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] lit_e_n;
    logic [CW-1:0] run_e_n;
  } plan_t;

  typedef struct packed {
    logic                                src_lit;
    logic [tga_rle_pkg::IDX_W-1:0]       idx;
    logic                                has_hdr;
    logic [tga_rle_pkg::HDR_W-1:0]       hdr;
    logic                                group_end;
    logic                                last_step;
    logic                                img_done;
  } req_t;

  function automatic tga_rle_pkg::state_t job_after(tga_rle_pkg::state_t s, plan_t p);
    tga_rle_pkg::state_t r;
    r = tga_rle_pkg::ST_IDLE;
    if (s < tga_rle_pkg::ST_RUN_A && p.run_a_n != '0) r = tga_rle_pkg::ST_RUN_A;
    else if (s < tga_rle_pkg::ST_LIT_A && p.lit_a_n != '0) r = tga_rle_pkg::ST_LIT_A;
    else if (s < tga_rle_pkg::ST_RUN_B && p.run_b) r = tga_rle_pkg::ST_RUN_B;
    else if (s < tga_rle_pkg::ST_WRITE && p.wr) r = tga_rle_pkg::ST_WRITE;
    else if (s < tga_rle_pkg::ST_LIT_E && p.lit_e_n != '0) r = tga_rle_pkg::ST_LIT_E;
    else if (s < tga_rle_pkg::ST_RUN_E && p.run_e_n != '0) r = tga_rle_pkg::ST_RUN_E;
    return r;
  endfunction

  // Memories
  logic [tga_rle_pkg::PIX_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [tga_rle_pkg::IDX_W-1:0] lit_mem [MAX_PACKET];

  // Control and encoder state
  tga_rle_pkg::state_t state_r, state_nxt;
  logic                rgb_mode_r;
  logic [CW-1:0]       lit_r, rep_r;
  logic [tga_rle_pkg::IDX_W-1:0] prev_r;
  logic                started_r;
  plan_t               plan_r, plan_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [tga_rle_pkg::IDX_W-1:0] runa_pix_r, cur_pix_r;
  logic                eoi_r;
  logic [CW-1:0]       lit1, rep1;

  logic in_acc, pix_acc, pal_acc, adv, wr_now;

  // Pipeline
  req_t iss;
  logic iss_valid;
  logic [AW-1:0] iss_addr;
  logic s1_valid_r, s2_valid_r;
  req_t s1_r, s2_r;
  logic [tga_rle_pkg::IDX_W-1:0] lit_rd_r, s1_idx;
  logic [tga_rle_pkg::PIX_W-1:0] pal_rd_r, px;
  logic s2_inr_r;

  // Assembly and output
  logic [tga_rle_pkg::SLOT_W-1:0] asm_cnt_r;
  logic [tga_rle_pkg::PIX_W-1:0]  asm_pix_r [tga_rle_pkg::PIXELS_PER_RESULT-1];
  logic                           asm_hdr_r;
  logic [tga_rle_pkg::HDR_W-1:0]  asm_hb_r;
  logic [tga_rle_pkg::PIX_W-1:0]  res_pix [tga_rle_pkg::PIXELS_PER_RESULT];
  logic                           out_valid_r;
  tga_rle_pkg::enc_out_t          out_data_r;

  // Issue job decode
  logic          is_run;
  logic [CW-1:0] job_n, job_nm1;
  logic          job_last_pix, emit_last;
  tga_rle_pkg::state_t nxt_job;

  assign in_stall = !(state_r == tga_rle_pkg::ST_IDLE && !s1_valid_r);
  assign in_acc   = in_valid && !in_stall;
  assign pix_acc  = in_acc && (in_data.cmd == tga_rle_pkg::CMD_PIXEL);
  assign pal_acc  = in_acc && (in_data.cmd == tga_rle_pkg::CMD_PALETTE);
  assign adv      = !(s2_valid_r && s2_r.group_end && out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Packet decisions for an incoming pixel, in the order the packets leave.
  always_comb begin
    plan_nxt = '0;
    lit1     = lit_r;
    rep1     = rep_r;
    if (!started_r) begin
      plan_nxt.wr      = 1'b1;
      plan_nxt.wr_addr = '0;
      lit1             = CW'(1);
      rep1             = '0;
    end else if (in_data.pixel_index == prev_r) begin
      if (lit_r != '0) begin
        // The last literal joins the new run, so it leaves the literal packet.
        plan_nxt.lit_a_n = lit_r - CW'(1);
        lit1             = '0;
        rep1             = CW'(2);
      end else begin
        rep1 = rep_r + CW'(1);
      end
      if (rep1 >= CW'(MAX_PACKET)) begin
        plan_nxt.run_b = 1'b1;
        rep1           = '0;
      end
    end else begin
      plan_nxt.run_a_n = rep_r;
      rep1             = '0;
      plan_nxt.wr      = 1'b1;
      if (lit_r >= CW'(MAX_PACKET)) begin
        plan_nxt.lit_a_n = lit_r;
        plan_nxt.wr_addr = '0;
        lit1             = CW'(1);
      end else begin
        plan_nxt.wr_addr = lit_r[AW-1:0];
        lit1             = lit_r + CW'(1);
      end
    end
    if (in_data.end_of_image) begin
      plan_nxt.lit_e_n = lit1;
      plan_nxt.run_e_n = (lit1 == '0) ? rep1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_mode_r <= 1'b0;
      lit_r      <= '0;
      rep_r      <= '0;
      prev_r     <= '0;
      started_r  <= 1'b0;
    end else begin
      if (cfg_we) rgb_mode_r <= cfg_wdata;
      if (pix_acc) begin
        lit_r     <= in_data.end_of_image ? '0 : lit1;
        rep_r     <= in_data.end_of_image ? '0 : rep1;
        prev_r    <= in_data.end_of_image ? '0 : in_data.pixel_index;
        started_r <= !in_data.end_of_image;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      plan_r     <= plan_nxt;
      runa_pix_r <= prev_r;
      cur_pix_r  <= in_data.pixel_index;
      eoi_r      <= in_data.end_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tga_rle_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    is_run  = (state_r == tga_rle_pkg::ST_RUN_A) || (state_r == tga_rle_pkg::ST_RUN_B) ||
              (state_r == tga_rle_pkg::ST_RUN_E);
    case (state_r)
      tga_rle_pkg::ST_RUN_A: job_n = plan_r.run_a_n;
      tga_rle_pkg::ST_LIT_A: job_n = plan_r.lit_a_n;
      tga_rle_pkg::ST_RUN_B: job_n = CW'(MAX_PACKET);
      tga_rle_pkg::ST_LIT_E: job_n = plan_r.lit_e_n;
      tga_rle_pkg::ST_RUN_E: job_n = plan_r.run_e_n;
      default:               job_n = '0;
    endcase
    job_nm1      = job_n - CW'(1);
    job_last_pix = is_run || (idx_r == job_nm1);
    nxt_job      = job_after(state_r, plan_r);
    emit_last    = (nxt_job == tga_rle_pkg::ST_IDLE) ||
                   (nxt_job == tga_rle_pkg::ST_WRITE &&
                    job_after(tga_rle_pkg::ST_WRITE, plan_r) == tga_rle_pkg::ST_IDLE);

    iss.src_lit   = !is_run;
    iss.idx       = (state_r == tga_rle_pkg::ST_RUN_A) ? runa_pix_r : cur_pix_r;
    iss.has_hdr   = is_run || (idx_r == '0);
    iss.hdr       = iss.has_hdr ?
                    ((tga_rle_pkg::HDR_W'(job_nm1) & tga_rle_pkg::COUNT_MASK) |
                     (is_run ? tga_rle_pkg::RUN_FLAG : '0)) : '0;
    iss.group_end = job_last_pix ||
                    (idx_r[tga_rle_pkg::SLOT_W-1:0] ==
                     tga_rle_pkg::SLOT_W'(tga_rle_pkg::PIXELS_PER_RESULT - 1));
    iss.last_step = job_last_pix && emit_last;
    iss.img_done  = job_last_pix && emit_last && eoi_r;
    iss_addr      = idx_r[AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    iss_valid = 1'b0;
    wr_now    = 1'b0;
    unique case (state_r) inside
      tga_rle_pkg::ST_IDLE: begin
        if (pix_acc) state_nxt = job_after(tga_rle_pkg::ST_IDLE, plan_nxt);
      end
      tga_rle_pkg::ST_RUN_A, tga_rle_pkg::ST_RUN_B, tga_rle_pkg::ST_RUN_E: begin
        iss_valid = 1'b1;
        if (adv) state_nxt = nxt_job;
      end
      tga_rle_pkg::ST_LIT_A, tga_rle_pkg::ST_LIT_E: begin
        iss_valid = 1'b1;
        if (adv) begin
          if (job_last_pix) begin
            idx_nxt   = '0;
            state_nxt = nxt_job;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      tga_rle_pkg::ST_WRITE: begin
        wr_now    = 1'b1;
        state_nxt = nxt_job;
      end
      default: state_nxt = tga_rle_pkg::ST_IDLE;
    endcase
  end

  // Literal store: the deferred write of a new literal lands after any flush read.
  always_ff @(posedge clk) begin
    if (wr_now) lit_mem[plan_r.wr_addr] <= cur_pix_r;
    if (adv) lit_rd_r <= lit_mem[iss_addr];
  end

  assign s1_idx = s1_r.src_lit ? lit_rd_r : s1_r.idx;

  // Palette: writes only while no pixel waits for its palette read.
  always_ff @(posedge clk) begin
    if (pal_acc && ({1'b0, in_data.pixel_index} < 9'(PALETTE_DEPTH)))
      pal_mem[in_data.pixel_index[PW-1:0]] <= {in_data.blue, in_data.green, in_data.red};
    if (adv) pal_rd_r <= pal_mem[s1_idx[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= iss_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= iss;
      s2_r     <= s1_r;
      s2_r.idx <= s1_idx;
      s2_inr_r <= ({1'b0, s1_idx} < 9'(PALETTE_DEPTH));
    end
  end

  always_comb begin
    if (!rgb_mode_r) px = tga_rle_pkg::PIX_W'(s2_r.idx);
    else if (s2_inr_r) px = pal_rd_r;
    else px = '0;
    for (int i = 0; i < tga_rle_pkg::PIXELS_PER_RESULT; i++) begin
      if (i < int'(asm_cnt_r)) res_pix[i] = asm_pix_r[i];
      else if (i == int'(asm_cnt_r)) res_pix[i] = px;
      else res_pix[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_stall) out_valid_r <= 1'b0;
      if (adv && s2_valid_r) begin
        if (s2_r.group_end) begin
          asm_cnt_r   <= '0;
          out_valid_r <= 1'b1;
        end else begin
          asm_cnt_r <= asm_cnt_r + tga_rle_pkg::SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      if (s2_r.group_end) begin
        out_data_r.has_header   <= (asm_cnt_r == '0) ? s2_r.has_hdr : asm_hdr_r;
        out_data_r.header_byte  <= (asm_cnt_r == '0) ? s2_r.hdr : asm_hb_r;
        out_data_r.pixel_count  <= tga_rle_pkg::CNT_W'(asm_cnt_r) + tga_rle_pkg::CNT_W'(1);
        out_data_r.pixel_a      <= res_pix[0];
        out_data_r.pixel_b      <= res_pix[1];
        out_data_r.pixel_c      <= res_pix[2];
        out_data_r.pixel_d      <= res_pix[3];
        out_data_r.last_of_step <= s2_r.last_step;
        out_data_r.image_done   <= s2_r.img_done;
      end else begin
        asm_pix_r[asm_cnt_r] <= px;
        if (asm_cnt_r == '0) begin
          asm_hdr_r <= s2_r.has_hdr;
          asm_hb_r  <= s2_r.hdr;
        end
      end
    end
  end

endmodule

// ===== hdl/tga_rle_checker.sv =====
// Port-level checker for the Targa RLE pixel encoder, bound to the top level.
module tga_rle_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input tga_rle_pkg::enc_out_t out_data
);

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_count != 3'd0) && (out_data.pixel_count <= 3'd4))
    else $error("pixel count out of range");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_done |-> out_data.last_of_step)
    else $error("image done without last of step");

  // A repeat packet always carries exactly one pixel.
  a_repeat_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_header && out_data.header_byte[7] |->
      out_data.pixel_count == 3'd1)
    else $error("repeat packet with more than one pixel");

  a_no_stray_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_header |-> out_data.header_byte == 8'h00)
    else $error("header byte set on a continuation beat");

endmodule

bind tga_rle_pixel_encoder_core tga_rle_checker u_tga_rle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tga_rle_score_pkg.sv =====
// Scoreboard class that predicts the encoder's packet beats and checks the ones it emits.
`timescale 1ns / 1ps
package tga_rle_score_pkg;
  import tga_rle_pkg::*;

  localparam int MAX_RUN      = 128;
  localparam int REPORT_LIMIT = 40;

  class packet_scoreboard;
    logic [PIX_W-1:0] color_table [256];
    logic [IDX_W-1:0] literal_buf [MAX_RUN];
    int unsigned      literal_len;
    int unsigned      run_len;
    logic [IDX_W-1:0] last_index;
    bit               open_image;
    bit               rgb_mode;
    enc_out_t         expected_beats [$];
    int               errors;

    function new();
      foreach (color_table[i]) color_table[i] = '0;
      foreach (literal_buf[i]) literal_buf[i] = '0;
      literal_len = 0;
      run_len     = 0;
      last_index  = '0;
      open_image  = 1'b0;
      rgb_mode    = 1'b0;
      errors      = 0;
    endfunction

    // Translation happens when a packet is emitted, not when the pixel arrives.
    function logic [PIX_W-1:0] to_pixel(logic [IDX_W-1:0] idx);
      if (rgb_mode) return color_table[idx];
      return {{(PIX_W-IDX_W){1'b0}}, idx};
    endfunction

    function void put_beat(bit hdr, logic [HDR_W-1:0] header, int unsigned count,
                           logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                           logic [PIX_W-1:0] p2, logic [PIX_W-1:0] p3);
      enc_out_t b;
      b = '0;
      b.has_header  = hdr;
      b.header_byte = hdr ? header : '0;
      b.pixel_count = CNT_W'(count);
      b.pixel_a     = p0;
      b.pixel_b     = p1;
      b.pixel_c     = p2;
      b.pixel_d     = p3;
      expected_beats.push_back(b);
    endfunction

    function void push_run(int unsigned n, logic [IDX_W-1:0] idx);
      put_beat(1'b1, RUN_FLAG | (HDR_W'(n - 1) & COUNT_MASK), 1, to_pixel(idx), '0, '0, '0);
    endfunction

    function void push_literal(int unsigned n);
      int unsigned      i;
      int unsigned      k;
      logic [PIX_W-1:0] pix [4];
      i = 0;
      while (i < n) begin
        k = 0;
        for (int s = 0; s < 4; s++) pix[s] = '0;
        while (k < PIXELS_PER_RESULT && i + k < n) begin
          pix[k] = to_pixel(literal_buf[i + k]);
          k++;
        end
        put_beat(i == 0, HDR_W'(n - 1) & COUNT_MASK, k, pix[0], pix[1], pix[2], pix[3]);
        i += k;
      end
    endfunction

    function void stash(logic [IDX_W-1:0] p);
      literal_buf[literal_len % MAX_RUN] = p;
      literal_len++;
    endfunction

    // Works out the beats caused by one accepted input beat.
    function void note_beat(enc_in_t beat);
      int unsigned      mark;
      enc_out_t         tail;
      logic [IDX_W-1:0] p;
      mark = expected_beats.size();
      p = beat.pixel_index;
      if (beat.cmd == CMD_PALETTE) begin
        color_table[p] = {beat.blue, beat.green, beat.red};
        return;
      end
      if (!open_image) begin
        literal_len = 0;
        run_len     = 0;
        stash(p);
        open_image = 1'b1;
      end else if (p == last_index) begin
        // The previous pixel was the tail of a literal; it now opens a run of two.
        if (literal_len > 0) begin
          if (literal_len > 1) push_literal(literal_len - 1);
          literal_len = 0;
          run_len     = 2;
        end else begin
          run_len++;
        end
        if (run_len >= MAX_RUN) begin
          push_run(MAX_RUN, last_index);
          run_len = 0;
        end
      end else begin
        if (run_len > 0) begin
          push_run(run_len, last_index);
          run_len = 0;
        end
        if (literal_len >= MAX_RUN) begin
          push_literal(literal_len);
          literal_len = 0;
        end
        stash(p);
      end
      last_index = p;
      if (beat.end_of_image) begin
        if (literal_len > 0) push_literal(literal_len);
        else if (run_len > 0) push_run(run_len, last_index);
        literal_len = 0;
        run_len     = 0;
        last_index  = '0;
        open_image  = 1'b0;
      end
      if (expected_beats.size() > mark) begin
        tail = expected_beats.pop_back();
        tail.last_of_step = 1'b1;
        tail.image_done   = beat.end_of_image;
        expected_beats.push_back(tail);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_beat(enc_out_t got);
      enc_out_t want;
      if (expected_beats.size() == 0) begin
        report("beat with nothing expected", got.header_byte, 0);
        return;
      end
      want = expected_beats.pop_front();
      if (got.has_header !== want.has_header)
        report("has_header", got.has_header, want.has_header);
      if (got.header_byte !== want.header_byte)
        report("header_byte", got.header_byte, want.header_byte);
      if (got.pixel_count !== want.pixel_count)
        report("pixel_count", got.pixel_count, want.pixel_count);
      if (got.pixel_a !== want.pixel_a) report("pixel_a", got.pixel_a, want.pixel_a);
      if (got.pixel_b !== want.pixel_b) report("pixel_b", got.pixel_b, want.pixel_b);
      if (got.pixel_c !== want.pixel_c) report("pixel_c", got.pixel_c, want.pixel_c);
      if (got.pixel_d !== want.pixel_d) report("pixel_d", got.pixel_d, want.pixel_d);
      if (got.last_of_step !== want.last_of_step)
        report("last_of_step", got.last_of_step, want.last_of_step);
      if (got.image_done !== want.image_done)
        report("image_done", got.image_done, want.image_done);
    endtask
  endclass

endpackage

// ===== tb/tga_rle_pixel_encoder_core_test.sv =====
// Testbench top: drives palette and pixel beats into the encoder and checks its packets.
`timescale 1ns / 1ps
module tga_rle_pixel_encoder_core_test;
  import tga_rle_pkg::*;
  import tga_rle_score_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 40;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  enc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  enc_out_t out_data;

  packet_scoreboard board;
  bit               written [256];
  logic [IDX_W-1:0] written_list [$];
  logic [IDX_W-1:0] last_sent   = '0;
  bit               calm_input  = 1'b0;
  int               items_sent  = 0;
  int               idle_cycles = 0;

  tga_rle_pixel_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // In RGB mode only palette entries that were written may be read.
  function automatic logic [IDX_W-1:0] pick_index(bit known_only);
    if (known_only) return written_list[$urandom_range(0, written_list.size() - 1)];
    return IDX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IDX_W-1:0] pick_other(bit known_only);
    logic [IDX_W-1:0] v;
    do v = pick_index(known_only); while (v == last_sent);
    return v;
  endfunction

  task automatic send_beat(enc_in_t item);
    int gap;
    gap = calm_input ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    board.note_beat(item);
    items_sent++;
  endtask

  task automatic send_pixel(logic [IDX_W-1:0] idx, bit eoi);
    enc_in_t item;
    item.cmd          = CMD_PIXEL;
    item.pixel_index  = idx;
    item.red          = 8'($urandom_range(0, 255));
    item.green        = 8'($urandom_range(0, 255));
    item.blue         = 8'($urandom_range(0, 255));
    item.end_of_image = eoi;
    last_sent = idx;
    send_beat(item);
  endtask

  task automatic send_palette(logic [IDX_W-1:0] addr, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, bit eoi);
    enc_in_t item;
    item.cmd          = CMD_PALETTE;
    item.pixel_index  = addr;
    item.red          = r;
    item.green        = g;
    item.blue         = b;
    item.end_of_image = eoi;
    if (!written[addr]) begin
      written[addr] = 1'b1;
      written_list.push_back(addr);
    end
    send_beat(item);
  endtask

  task automatic send_random_palette();
    send_palette(IDX_W'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 1));
  endtask

  task automatic send_run(logic [IDX_W-1:0] v, int len, bit eoi);
    for (int i = 0; i < len; i++) send_pixel(v, eoi && (i == len - 1));
  endtask

  task automatic send_literal(int len, bit known_only, bit eoi);
    for (int i = 0; i < len; i++) send_pixel(pick_other(known_only), eoi && (i == len - 1));
  endtask

  task automatic random_segment(bit known_only);
    int kind;
    int len;
    bit eoi;
    kind = $urandom_range(0, 9);
    calm_input = ($urandom_range(0, 5) == 0);
    eoi = ($urandom_range(0, 5) == 0);
    case (kind)
      0, 1, 2, 3: begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
        send_run(pick_index(known_only), len, eoi);
      end
      4, 5, 6: send_literal($urandom_range(1, 9), known_only, eoi);
      7: send_random_palette();
      8: send_pixel(pick_index(known_only), 1'b1);
      default: send_literal($urandom_range(12, 24), known_only, eoi);
    endcase
  endtask

  task automatic random_phase(bit known_only, int target, bit close_image);
    int start;
    start = items_sent;
    while (items_sent - start < target) random_segment(known_only);
    calm_input = 1'b0;
    if (close_image) send_pixel(pick_index(known_only), 1'b1);
  endtask

  // The mode register is written only once the encoder has drained.
  task automatic set_mode(bit m);
    in_valid <= 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.rgb_mode = m;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_beat(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL tga_rle_pixel_encoder_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output back-pressure: mostly short stalls, a few long ones, and stretches without any.
  initial begin : out_pacing
    int len;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats in index mode.
    set_mode(1'b0);
    send_palette(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);  // the end flag must be ignored here
    send_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_palette(8'h5A, 8'h12, 8'h34, 8'h56, 1'b0);
    send_palette(8'hA5, 8'hED, 8'hCB, 8'hA9, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_run(8'h07, 3, 1'b0);
    send_pixel(8'h09, 1'b1);
    send_pixel(8'h01, 1'b0);
    send_run(8'h02, 2, 1'b1);

    // RGB mode: load part of the palette, then encode only known entries.
    set_mode(1'b1);
    repeat (24) send_random_palette();
    random_phase(1'b1, 50, 1'b0);
    // A run of exactly one full packet, then one equal pixel that ends the image.
    send_run(pick_other(1'b1), MAX_RUN, 1'b0);
    send_pixel(last_sent, 1'b1);
    random_phase(1'b1, 20, 1'b0);
    send_literal(3, 1'b1, 1'b0);

    // Switch to index mode with the image still open.
    set_mode(1'b0);
    random_phase(1'b0, 30, 1'b0);
    send_literal(MAX_RUN + 3, 1'b0, 1'b1);
    random_phase(1'b0, 30, 1'b1);

    set_mode(1'b1);
    random_phase(1'b1, 60, 1'b1);

    set_mode(1'b0);
    random_phase(1'b0, 30, 1'b1);

    in_valid <= 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS tga_rle_pixel_encoder_core");
    end else begin
      $display("FAIL tga_rle_pixel_encoder_core");
    end
    $finish;
  end

endmodule
